[hdl/tlvv_pkg.sv]
// ----------------------------------------------------------------------------
// tlvv_pkg
// Shared types and status codes for the tlv payload validator.
// ----------------------------------------------------------------------------
package tlvv_pkg;

    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 4;
    localparam int LEN_W    = 16;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 4'd0;
    localparam logic [STATUS_W-1:0] ST_HDR_SHORT = 4'd1;
    localparam logic [STATUS_W-1:0] ST_NO_LEN    = 4'd2;
    localparam logic [STATUS_W-1:0] ST_TRUNC     = 4'd3;
    localparam logic [STATUS_W-1:0] ST_NO_IDLEN  = 4'd4;
    localparam logic [STATUS_W-1:0] ST_ID_LONG   = 4'd5;
    localparam logic [STATUS_W-1:0] ST_REC_SHORT = 4'd6;
    localparam logic [STATUS_W-1:0] ST_REC_OVF   = 4'd7;
    localparam logic [STATUS_W-1:0] ST_BAD_TYPE  = 4'd8;

    // accepted record types
    localparam logic [BYTE_W-1:0] TYPE_A = 8'h40;
    localparam logic [BYTE_W-1:0] TYPE_B = 8'h41;
    localparam logic [BYTE_W-1:0] TYPE_C = 8'h42;

    // minimum sizes
    localparam logic [LEN_W-1:0] MIN_PAYLOAD = 16'd2;
    localparam logic [LEN_W-1:0] MIN_RECORD  = 16'd3;

    // one packet byte as held in the input stage
    typedef struct packed {
        logic [BYTE_W-1:0] byte_val;
        logic              last;
    } item_t;

    // parser output toward the result register
    typedef struct packed {
        logic                valid;
        logic [STATUS_W-1:0] status;
    } result_t;

endpackage

[hdl/tlv_payload_validator_top.sv]
// ----------------------------------------------------------------------------
// tlv_payload_validator_top
// Byte-serial validator for length-prefixed packets of type-length-value
// records, one status per packet.
// ----------------------------------------------------------------------------
// Each request is one packet byte plus a last-byte flag. The block skips
// HEADER_BYTES header bytes, reads a 16-bit little-endian payload length, then
// a 16-bit little-endian identifier length and skips the identifier, and
// checks the rest of the payload as records (type byte, length byte, value
// bytes; types 0x40, 0x41, 0x42 only). The first content error is held; on
// the last byte one status is sent on the m_ channel and the parser returns to
// its reset state. Truncation (header, length or payload) outranks held
// errors; bytes past the payload are ignored. Bytes without the last flag give
// no result. Throughput is one byte per cycle while no last byte stalls: the
// full parse update for a byte is a single pass of compares and 16-bit and
// 8-bit counter steps between the input register and the result register;
// the result register takes the status as the parser takes the last byte.
// The input side keeps taking bytes while a status waits in the result
// register; only a second last byte stalls behind it.
// ----------------------------------------------------------------------------
module tlv_payload_validator_top #(
    parameter int HEADER_BYTES = 5
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [tlvv_pkg::BYTE_W-1:0]   s_byte_in,
    input  logic                          s_is_last,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [tlvv_pkg::STATUS_W-1:0] m_status
);

    tlvv_pkg::item_t   s_item;
    tlvv_pkg::item_t   item;
    logic              item_valid;
    logic              take;
    tlvv_pkg::result_t result;

    assign s_item.byte_val = s_byte_in;
    assign s_item.last     = s_is_last;

    // a byte moves on unless it ends a packet while the result slot is full and m_ready is low
    assign take = item_valid && (!item.last || !m_valid || m_ready);

    // input register
    tlvv_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    // parse state and per-byte update
    tlvv_parser #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take    (take),
        .item    (item),
        .result  (result)
    );

    // result register
    tlvv_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .result   (result),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_status (m_status)
    );

`ifndef SYNTH
    // status codes stay within the defined set
    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status <= tlvv_pkg::ST_BAD_TYPE))
        else $error("status code out of range");

    // a finished packet always shows up on the result channel
    a_result_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        result.valid |=> (m_valid && m_status == $past(result.status)))
        else $error("packet status not loaded into result register");

    // a held byte is never dropped or changed while stalled
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_valid && !take) |=> (item_valid && $stable(item)))
        else $error("input byte lost while stalled");

    // no status is produced over one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !result.valid)
        else $error("result overwritten before taken");
`endif

endmodule

[hdl/tlvv_in_reg.sv]
// ----------------------------------------------------------------------------
// tlvv_in_reg
// Input register: captures one request and holds it until the parser takes it.
// ----------------------------------------------------------------------------
module tlvv_in_reg (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  tlvv_pkg::item_t s_item,
    input  logic            take,
    output logic            item_valid,
    output tlvv_pkg::item_t item
);

    logic            valid_reg;
    logic            valid_next;
    tlvv_pkg::item_t item_reg;

    assign s_ready    = !valid_reg || take;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[hdl/tlvv_parser.sv]
// ----------------------------------------------------------------------------
// tlvv_parser
// Packet parse state and its combinational update for one byte.
// ----------------------------------------------------------------------------
module tlvv_parser #(
    parameter int HEADER_BYTES = 5
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              take,
    input  tlvv_pkg::item_t   item,
    output tlvv_pkg::result_t result
);

    typedef enum logic [2:0] {
        PH_HDR      = 3'd0,
        PH_LEN_LO   = 3'd1,
        PH_LEN_HI   = 3'd2,
        PH_IDL_LO   = 3'd3,
        PH_IDL_HI   = 3'd4,
        PH_SKIP     = 3'd5,
        PH_REC_TYPE = 3'd6,
        PH_REC_LEN  = 3'd7
    } phase_t;

    localparam phase_t PHASE_INIT = (HEADER_BYTES == 0) ? PH_LEN_LO : PH_HDR;
    localparam int     HC_W       = tlvv_pkg::BYTE_W;

    phase_t                          phase_reg, phase_next;
    logic [HC_W-1:0]                 hcount_reg, hcount_next;
    logic [tlvv_pkg::BYTE_W-1:0]     low_reg, low_next;
    logic [tlvv_pkg::LEN_W-1:0]      pleft_reg, pleft_next;
    logic [tlvv_pkg::LEN_W-1:0]      ileft_reg, ileft_next;
    logic [tlvv_pkg::BYTE_W-1:0]     rtype_reg, rtype_next;
    logic [tlvv_pkg::BYTE_W-1:0]     rleft_reg, rleft_next;
    logic [tlvv_pkg::STATUS_W-1:0]   err_reg, err_next;

    logic [HC_W:0]                   hcount_inc;
    logic [tlvv_pkg::LEN_W-1:0]      pleft_dec;
    logic [tlvv_pkg::LEN_W-1:0]      word_val;
    logic [tlvv_pkg::LEN_W-1:0]      byte_wide;
    logic                            known_type;
    logic [tlvv_pkg::STATUS_W-1:0]   status;

    assign hcount_inc = {1'b0, hcount_reg} + {{HC_W{1'b0}}, 1'b1};
    assign pleft_dec  = pleft_reg - {{(tlvv_pkg::LEN_W-1){1'b0}}, 1'b1};
    assign word_val   = {item.byte_val, low_reg};
    assign byte_wide  = {{(tlvv_pkg::LEN_W-tlvv_pkg::BYTE_W){1'b0}}, item.byte_val};
    assign known_type = (rtype_reg == tlvv_pkg::TYPE_A) || (rtype_reg == tlvv_pkg::TYPE_B)
                        || (rtype_reg == tlvv_pkg::TYPE_C);

    always_comb begin
        phase_next  = phase_reg;
        hcount_next = hcount_reg;
        low_next    = low_reg;
        pleft_next  = pleft_reg;
        ileft_next  = ileft_reg;
        rtype_next  = rtype_reg;
        rleft_next  = rleft_reg;
        err_next    = err_reg;

        unique case (phase_reg)
            PH_HDR: begin
                hcount_next = hcount_inc[HC_W-1:0];
                if (hcount_inc >= (HC_W+1)'(HEADER_BYTES)) begin
                    phase_next = PH_LEN_LO;
                end
            end
            PH_LEN_LO: begin
                low_next   = item.byte_val;
                phase_next = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                pleft_next = word_val;
                if (word_val < tlvv_pkg::MIN_PAYLOAD && err_reg == tlvv_pkg::ST_OK) begin
                    err_next = tlvv_pkg::ST_NO_IDLEN;
                end
                phase_next = PH_IDL_LO;
            end
            default: begin
                // payload byte: counted while payload remains, parsed only while no error
                if (pleft_reg != '0) begin
                    pleft_next = pleft_dec;
                    if (err_reg == tlvv_pkg::ST_OK) begin
                        unique case (phase_reg)
                            PH_IDL_LO: begin
                                low_next   = item.byte_val;
                                phase_next = PH_IDL_HI;
                            end
                            PH_IDL_HI: begin
                                if (pleft_dec < word_val) begin
                                    err_next = tlvv_pkg::ST_ID_LONG;
                                end else begin
                                    ileft_next = word_val;
                                    phase_next = (word_val != '0) ? PH_SKIP : PH_REC_TYPE;
                                end
                            end
                            PH_SKIP: begin
                                if (ileft_reg != '0) begin
                                    ileft_next = ileft_reg - {{(tlvv_pkg::LEN_W-1){1'b0}}, 1'b1};
                                end else if (rleft_reg != '0) begin
                                    rleft_next = rleft_reg - {{(tlvv_pkg::BYTE_W-1){1'b0}}, 1'b1};
                                end
                                if (ileft_next == '0 && rleft_next == '0) begin
                                    phase_next = PH_REC_TYPE;
                                end
                            end
                            PH_REC_TYPE: begin
                                if (pleft_reg < tlvv_pkg::MIN_RECORD) begin
                                    err_next = tlvv_pkg::ST_REC_SHORT;
                                end else begin
                                    rtype_next = item.byte_val;
                                    phase_next = PH_REC_LEN;
                                end
                            end
                            PH_REC_LEN: begin
                                if (byte_wide > pleft_dec) begin
                                    err_next = tlvv_pkg::ST_REC_OVF;
                                end else if (!known_type) begin
                                    err_next = tlvv_pkg::ST_BAD_TYPE;
                                end else begin
                                    rleft_next = item.byte_val;
                                    phase_next = (item.byte_val != '0) ? PH_SKIP : PH_REC_TYPE;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
        endcase
    end

    // end-of-packet status, truncation ahead of latched errors
    always_comb begin
        if (phase_next == PH_HDR) begin
            status = tlvv_pkg::ST_HDR_SHORT;
        end else if (phase_next == PH_LEN_LO || phase_next == PH_LEN_HI) begin
            status = tlvv_pkg::ST_NO_LEN;
        end else if (pleft_next != '0) begin
            status = tlvv_pkg::ST_TRUNC;
        end else begin
            status = err_next;
        end
    end

    assign result.valid  = take && item.last;
    assign result.status = status;

    always_ff @(posedge aclk) begin
        if (!aresetn || (take && item.last)) begin
            phase_reg  <= PHASE_INIT;
            hcount_reg <= '0;
            low_reg    <= '0;
            pleft_reg  <= '0;
            ileft_reg  <= '0;
            rtype_reg  <= '0;
            rleft_reg  <= '0;
            err_reg    <= tlvv_pkg::ST_OK;
        end else if (take) begin
            phase_reg  <= phase_next;
            hcount_reg <= hcount_next;
            low_reg    <= low_next;
            pleft_reg  <= pleft_next;
            ileft_reg  <= ileft_next;
            rtype_reg  <= rtype_next;
            rleft_reg  <= rleft_next;
            err_reg    <= err_next;
        end
    end

endmodule

[hdl/tlvv_out_reg.sv]
// ----------------------------------------------------------------------------
// tlvv_out_reg
// Result register: holds one status until the downstream side takes it.
// ----------------------------------------------------------------------------
module tlvv_out_reg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  tlvv_pkg::result_t             result,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [tlvv_pkg::STATUS_W-1:0] m_status
);

    logic                          valid_reg;
    logic                          valid_next;
    logic [tlvv_pkg::STATUS_W-1:0] status_reg;

    assign valid_next = result.valid || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (result.valid) begin
            status_reg <= result.status;
        end
    end

    assign m_valid  = valid_reg;
    assign m_status = status_reg;

endmodule
